### rtl/igp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package igp_pkg;

	localparam logic signed [23:0] GYRO_GAIN_Q16 = 24'sd4575276;
	localparam logic signed [33:0] HZ_BIAS = 34'sd536870912;
	localparam int SQRT_CELLS = 32;
	localparam int DIV_CELLS = 15;

	typedef struct packed {
		logic signed [15:0] gyro_x_raw;
		logic signed [15:0] gyro_y_raw;
		logic signed [15:0] gyro_z_raw;
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
	} sample_t;

	typedef struct packed {
		logic signed [23:0] rate_forward;
		logic signed [23:0] rate_left;
		logic signed [23:0] rate_up;
		logic [2:0]         neg;
		logic [31:0]        mag_x;
		logic [31:0]        mag_y;
		logic [31:0]        mag_z;
	} carry_t;

	typedef struct packed {
		carry_t      c;
		logic [63:0] rem;
		logic [63:0] root;
	} sqrt_t;

	typedef struct packed {
		logic signed [23:0] rate_forward;
		logic signed [23:0] rate_left;
		logic signed [23:0] rate_up;
		logic [2:0]         neg;
		logic [31:0]        norm;
		logic [47:0]        rem_x;
		logic [47:0]        rem_y;
		logic [47:0]        rem_z;
		logic [14:0]        q_x;
		logic [14:0]        q_y;
		logic [14:0]        q_z;
	} div_t;

endpackage
`default_nettype wire

### rtl/igp_sample_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface igp_sample_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] gyro_x_raw;
	logic signed [15:0] gyro_y_raw;
	logic signed [15:0] gyro_z_raw;
	logic signed [15:0] quat_w;
	logic signed [15:0] quat_x;
	logic signed [15:0] quat_y;
	logic signed [15:0] quat_z;

	modport source(output valid, gyro_x_raw, gyro_y_raw, gyro_z_raw,
		quat_w, quat_x, quat_y, quat_z, input ready);
	modport sink(input valid, gyro_x_raw, gyro_y_raw, gyro_z_raw,
		quat_w, quat_x, quat_y, quat_z, output ready);
endinterface
`default_nettype wire

### rtl/igp_result_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface igp_result_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] rate_forward;
	logic signed [23:0] rate_left;
	logic signed [23:0] rate_up;
	logic signed [15:0] grav_forward;
	logic signed [15:0] grav_left;
	logic signed [15:0] grav_up;
	logic               norm_too_small;

	modport source(output valid, rate_forward, rate_left, rate_up,
		grav_forward, grav_left, grav_up, norm_too_small, input ready);
	modport sink(input valid, rate_forward, rate_left, rate_up,
		grav_forward, grav_left, grav_up, norm_too_small, output ready);
endinterface
`default_nettype wire

### rtl/igp_front.sv
`timescale 1ns / 1ps
`default_nettype none
module igp_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire igp_pkg::sample_t in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output igp_pkg::sqrt_t        out_data
);
	import igp_pkg::*;

	function automatic logic signed [23:0] round_rate(input logic signed [40:0] p);
		logic [40:0] mag;
		logic [40:0] r;
		mag = p[40] ? 41'(-p) : 41'(p);
		r = (mag + 41'd32768) >> 16;
		return p[40] ? -24'(r) : 24'(r);
	endfunction

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	logic signed [16:0] gx_neg;
	logic signed [31:0] p_xz_s1, p_wy_s1, p_yz_s1, p_wx_s1, p_xx_s1, p_yy_s1;
	logic signed [40:0] pr_f_s1, pr_l_s1, pr_u_s1;

	logic signed [32:0] hx, hy;
	logic signed [33:0] hz;
	carry_t c_s2, c_s3, c_s4;
	logic [63:0] sq_x_s3, sq_y_s3, sq_z_s3;
	logic [63:0] sum_s4;

	assign en4 = !v_s4 || out_ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	assign gx_neg = 17'sd0 - 17'(in_data.gyro_x_raw);
	assign hx = 33'(p_xz_s1) - 33'(p_wy_s1);
	assign hy = 33'(p_yz_s1) + 33'(p_wx_s1);
	assign hz = HZ_BIAS - (34'(p_xx_s1) + 34'(p_yy_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			p_xz_s1 <= in_data.quat_x * in_data.quat_z;
			p_wy_s1 <= in_data.quat_w * in_data.quat_y;
			p_yz_s1 <= in_data.quat_y * in_data.quat_z;
			p_wx_s1 <= in_data.quat_w * in_data.quat_x;
			p_xx_s1 <= in_data.quat_x * in_data.quat_x;
			p_yy_s1 <= in_data.quat_y * in_data.quat_y;
			pr_f_s1 <= 41'(in_data.gyro_y_raw) * 41'(GYRO_GAIN_Q16);
			pr_l_s1 <= 41'(gx_neg) * 41'(GYRO_GAIN_Q16);
			pr_u_s1 <= 41'(in_data.gyro_z_raw) * 41'(GYRO_GAIN_Q16);
		end
		if (en2) begin
			c_s2.rate_forward <= round_rate(pr_f_s1);
			c_s2.rate_left <= round_rate(pr_l_s1);
			c_s2.rate_up <= round_rate(pr_u_s1);
			c_s2.neg <= {hz[33], hy[32], hx[32]};
			c_s2.mag_x <= hx[32] ? 32'(-hx) : 32'(hx);
			c_s2.mag_y <= hy[32] ? 32'(-hy) : 32'(hy);
			c_s2.mag_z <= hz[33] ? 32'(-hz) : 32'(hz);
		end
		if (en3) begin
			c_s3 <= c_s2;
			sq_x_s3 <= 64'(c_s2.mag_x) * 64'(c_s2.mag_x);
			sq_y_s3 <= 64'(c_s2.mag_y) * 64'(c_s2.mag_y);
			sq_z_s3 <= 64'(c_s2.mag_z) * 64'(c_s2.mag_z);
		end
		if (en4) begin
			c_s4 <= c_s3;
			sum_s4 <= sq_x_s3 + sq_y_s3 + sq_z_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_data.c = c_s4;
	assign out_data.rem = sum_s4;
	assign out_data.root = 64'd0;
endmodule
`default_nettype wire

### rtl/igp_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module igp_sqrt_cell #(
	parameter int BIT_POS = 62
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire igp_pkg::sqrt_t in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output igp_pkg::sqrt_t      out_data
);
	import igp_pkg::*;

	logic [63:0] bitv;
	logic [63:0] trial;
	sqrt_t nxt;
	logic v_q;
	sqrt_t d_q;

	assign bitv = 64'd1 << BIT_POS;
	assign trial = in_data.root + bitv;

	always_comb begin
		nxt = in_data;
		if (in_data.rem >= trial) begin
			nxt.rem = in_data.rem - trial;
			nxt.root = (in_data.root >> 1) + bitv;
		end else begin
			nxt.root = in_data.root >> 1;
		end
	end

	assign in_ready = !v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) d_q <= nxt;
	end

	assign out_valid = v_q;
	assign out_data = d_q;
endmodule
`default_nettype wire

### rtl/igp_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module igp_div_cell #(
	parameter int QBIT = 14
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire igp_pkg::div_t in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output igp_pkg::div_t      out_data
);
	import igp_pkg::*;

	logic [47:0] dsh;
	div_t nxt;
	logic v_q;
	div_t d_q;

	assign dsh = 48'({in_data.norm, 1'b0}) << QBIT;

	always_comb begin
		nxt = in_data;
		if (in_data.rem_x >= dsh) begin
			nxt.rem_x = in_data.rem_x - dsh;
			nxt.q_x[QBIT] = 1'b1;
		end
		if (in_data.rem_y >= dsh) begin
			nxt.rem_y = in_data.rem_y - dsh;
			nxt.q_y[QBIT] = 1'b1;
		end
		if (in_data.rem_z >= dsh) begin
			nxt.rem_z = in_data.rem_z - dsh;
			nxt.q_z[QBIT] = 1'b1;
		end
	end

	assign in_ready = !v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) d_q <= nxt;
	end

	assign out_valid = v_q;
	assign out_data = d_q;
endmodule
`default_nettype wire

### rtl/imu_gyro_and_gravity_projection_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Modport  Contents
// sample   sink     raw gyro counts and Q15 quaternion, one IMU sample
// result   source   Q8.16 rates, Q2.14 projected gravity, zero-norm flag
//
// One transaction is accepted per cycle unless a stalled result backs up the chain of
// four front stages, 32 square-root cells (one root bit each), 15 divider cells (one
// quotient bit each for all three axes) and the output register.
// Reset clears only the valid bits of the chain. Each cell moves forward when its
// successor is empty or moving, so a stalled result fills the chain before the
// sample side stops.
module imu_gyro_and_gravity_projection_unit (
	input wire logic clk,
	input wire logic arst_n,
	igp_sample_if.sink sample,
	igp_result_if.source result
);
	import igp_pkg::*;

	sample_t s_in;
	logic  sq_v [0:SQRT_CELLS];
	logic  sq_r [0:SQRT_CELLS];
	sqrt_t sq_d [0:SQRT_CELLS];
	logic  dv_v [0:DIV_CELLS];
	logic  dv_r [0:DIV_CELLS];
	div_t  dv_d [0:DIV_CELLS];
	sqrt_t sq_last;
	logic  out_v_q;
	logic  out_en;
	logic  zero_norm;

	assign s_in.gyro_x_raw = sample.gyro_x_raw;
	assign s_in.gyro_y_raw = sample.gyro_y_raw;
	assign s_in.gyro_z_raw = sample.gyro_z_raw;
	assign s_in.quat_w = sample.quat_w;
	assign s_in.quat_x = sample.quat_x;
	assign s_in.quat_y = sample.quat_y;
	assign s_in.quat_z = sample.quat_z;

	igp_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(sample.valid), .in_ready(sample.ready), .in_data(s_in),
		.out_valid(sq_v[0]), .out_ready(sq_r[0]), .out_data(sq_d[0])
	);

	for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
		igp_sqrt_cell #(.BIT_POS(62 - 2 * k)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.in_valid(sq_v[k]), .in_ready(sq_r[k]), .in_data(sq_d[k]),
			.out_valid(sq_v[k+1]), .out_ready(sq_r[k+1]), .out_data(sq_d[k+1])
		);
	end

	assign sq_last = sq_d[SQRT_CELLS];
	assign dv_v[0] = sq_v[SQRT_CELLS];
	assign sq_r[SQRT_CELLS] = dv_r[0];
	assign dv_d[0].rate_forward = sq_last.c.rate_forward;
	assign dv_d[0].rate_left = sq_last.c.rate_left;
	assign dv_d[0].rate_up = sq_last.c.rate_up;
	assign dv_d[0].neg = sq_last.c.neg;
	assign dv_d[0].norm = sq_last.root[31:0];
	assign dv_d[0].rem_x = {1'b0, sq_last.c.mag_x, 15'd0} + 48'(sq_last.root[31:0]);
	assign dv_d[0].rem_y = {1'b0, sq_last.c.mag_y, 15'd0} + 48'(sq_last.root[31:0]);
	assign dv_d[0].rem_z = {1'b0, sq_last.c.mag_z, 15'd0} + 48'(sq_last.root[31:0]);
	assign dv_d[0].q_x = 15'd0;
	assign dv_d[0].q_y = 15'd0;
	assign dv_d[0].q_z = 15'd0;

	for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
		igp_div_cell #(.QBIT(DIV_CELLS - 1 - j)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.in_valid(dv_v[j]), .in_ready(dv_r[j]), .in_data(dv_d[j]),
			.out_valid(dv_v[j+1]), .out_ready(dv_r[j+1]), .out_data(dv_d[j+1])
		);
	end

	assign out_en = !out_v_q || result.ready;
	assign dv_r[DIV_CELLS] = out_en;
	assign zero_norm = (dv_d[DIV_CELLS].norm == 32'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_en) begin
			out_v_q <= dv_v[DIV_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (out_en) begin
			result.rate_forward <= dv_d[DIV_CELLS].rate_forward;
			result.rate_left <= dv_d[DIV_CELLS].rate_left;
			result.rate_up <= dv_d[DIV_CELLS].rate_up;
			result.norm_too_small <= zero_norm;
			if (zero_norm) begin
				result.grav_forward <= 16'sd0;
				result.grav_left <= 16'sd0;
				result.grav_up <= 16'sd0;
			end else begin
				result.grav_forward <= dv_d[DIV_CELLS].neg[1] ?
					$signed({1'b0, dv_d[DIV_CELLS].q_y}) :
					-$signed({1'b0, dv_d[DIV_CELLS].q_y});
				result.grav_left <= dv_d[DIV_CELLS].neg[0] ?
					-$signed({1'b0, dv_d[DIV_CELLS].q_x}) :
					$signed({1'b0, dv_d[DIV_CELLS].q_x});
				result.grav_up <= dv_d[DIV_CELLS].neg[2] ?
					$signed({1'b0, dv_d[DIV_CELLS].q_z}) :
					-$signed({1'b0, dv_d[DIV_CELLS].q_z});
			end
		end
	end

	assign result.valid = out_v_q;

	a_small_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.norm_too_small |->
		result.grav_forward == 16'sd0 && result.grav_left == 16'sd0 &&
		result.grav_up == 16'sd0)
		else $error("zero-norm result carries a nonzero gravity component");

	a_grav_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.grav_up <= 16'sd16384 && result.grav_up >= -16'sd16384 &&
		result.grav_left <= 16'sd16384 && result.grav_left >= -16'sd16384)
		else $error("normalized gravity component exceeds unit magnitude");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid &&
		$stable(result.rate_forward) && $stable(result.grav_forward) &&
		$stable(result.norm_too_small))
		else $error("waiting result transaction changed before it was taken");
endmodule
`default_nettype wire
